// ===== rtl/core/pad_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package pad_pkg;
   localparam logic [1:0] REQ_DEPOSIT    = 2'd0;
   localparam logic [1:0] REQ_READ_BIN   = 2'd1;
   localparam logic [1:0] REQ_READ_TOTAL = 2'd2;

   localparam logic [1:0] CSR_DEPTH_BIN_SIZE   = 2'd0;
   localparam logic [1:0] CSR_RADIUS_BIN_SIZE  = 2'd1;
   localparam logic [1:0] CSR_DEPTH_BINS_USED  = 2'd2;
   localparam logic [1:0] CSR_RADIUS_BINS_USED = 2'd3;

   localparam logic [16:0] ONE_Q16 = 17'd65536;
   localparam int READ_WIDTH = 48;
endpackage
`default_nettype wire

// ===== rtl/core/pad_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pad_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16384
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== rtl/core/photon_absorption_deposit_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel | ports                  | transfer
// req     | req_valid / req_ready  | deposit or read transaction in
// rsp     | rsp_valid / rsp_ready  | one result transaction out
// csr     | csr_write_enable       | register write, no wait
// a deposit runs a prep multiply, then a shared iteration loop for the weight divide,
// depth divide and root, a second loop for the radius divide, then bin check, ram read,
// modify-write and result register. bin, total and unused reads go straight to the ram
// read. the next transaction can be taken in the same cycle the result is raised.
// after reset a clearing pass zeroes every cell of the grid; no transaction is taken
// meanwhile. a result still waiting holds the next transaction just before its ram
// read until rsp_ready.
module photon_absorption_deposit_core #(
   parameter int DEPTH_BINS_MAX  = 128,
   parameter int RADIUS_BINS_MAX = 128,
   parameter int ACC_WIDTH       = 48
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_type,
   input  wire logic [16:0] req_weight_in,
   input  wire logic [31:0] req_pos_x,
   input  wire logic [31:0] req_pos_y,
   input  wire logic [31:0] req_pos_z,
   input  wire logic [31:0] req_absorb_coef,
   input  wire logic [31:0] req_scatter_coef,
   input  wire logic [6:0]  req_read_radius_bin,
   input  wire logic [6:0]  req_read_depth_bin,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [16:0]      rsp_weight_out,
   output logic [16:0]      rsp_absorbed,
   output logic             rsp_in_grid,
   output logic [47:0]      rsp_read_value,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_write_data
);
   localparam int CELLS  = RADIUS_BINS_MAX * DEPTH_BINS_MAX;
   localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_PREP, S_SUM, S_ITER1, S_ITER2, S_CHECK, S_WAIT, S_MODIFY, S_FIN
   } state_type;

   state_type state_ff;
   logic [ADDR_W-1:0] clr_ff;
   logic [4:0]  cnt_ff;
   logic [1:0]  type_ff;
   logic [16:0] w_ff;
   logic [31:0] mua_ff, ax_ff, ay_ff, zraw_ff;
   logic [32:0] csum_ff;
   logic [48:0] prod_ff;
   logic [63:0] axx_ff, ayy_ff, sv_ff;
   logic [32:0] rem1_ff, rem2_ff, rem3_ff;
   logic [16:0] p_ff;
   logic [31:0] zs_ff, rs_ff, root_ff;
   logic [34:0] srem_ff;
   logic        ok_ff, rd_ok_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [ACC_WIDTH-1:0] total_ff;
   logic [31:0] dz_ff, dr_ff;
   logic [7:0]  nz_ff, nr_ff;
   logic        rsp_valid_ff;
   logic [16:0] rsp_wout_ff, rsp_dwa_ff;
   logic        rsp_in_grid_ff;
   logic [47:0] rsp_val_ff;

   logic [ACC_WIDTH-1:0] ram_rd;
   logic                 ram_we;
   logic [ADDR_W-1:0]    ram_waddr;
   logic [ACC_WIDTH-1:0] ram_wdata;

   logic [33:0] t1;
   logic [32:0] t2, t3;
   logic [34:0] st, trial;
   logic [16:0] dwa;
   logic [31:0] nz, nr;
   logic [ACC_WIDTH:0] bin_sum, tot_sum;
   logic [ACC_WIDTH-1:0] bin_new, tot_new;
   logic [16:0] w_clamp;

   always_comb begin
      t1 = {rem1_ff, p_ff[16]};
      t2 = {rem2_ff[31:0], zs_ff[31]};
      t3 = {rem3_ff[31:0], rs_ff[31]};
      st = {srem_ff[32:0], sv_ff[63:62]};
      trial = {1'b0, root_ff, 2'b01};
      dwa = (csum_ff == 33'd0) ? 17'd0 : prod_ff[16:0];
      nz = (32'(nz_ff) > 32'(DEPTH_BINS_MAX)) ? 32'(DEPTH_BINS_MAX) : 32'(nz_ff);
      nr = (32'(nr_ff) > 32'(RADIUS_BINS_MAX)) ? 32'(RADIUS_BINS_MAX) : 32'(nr_ff);
      bin_sum = {1'b0, ram_rd} + (ACC_WIDTH+1)'(dwa);
      tot_sum = {1'b0, total_ff} + (ACC_WIDTH+1)'(dwa);
      bin_new = bin_sum[ACC_WIDTH] ? {ACC_WIDTH{1'b1}} : bin_sum[ACC_WIDTH-1:0];
      tot_new = tot_sum[ACC_WIDTH] ? {ACC_WIDTH{1'b1}} : tot_sum[ACC_WIDTH-1:0];
      w_clamp = (req_weight_in > pad_pkg::ONE_Q16) ? pad_pkg::ONE_Q16 : req_weight_in;
      ram_we = (state_ff == S_CLEAR)
            || (state_ff == S_MODIFY && type_ff == pad_pkg::REQ_DEPOSIT && ok_ff);
      ram_waddr = (state_ff == S_CLEAR) ? clr_ff : addr_ff;
      ram_wdata = (state_ff == S_CLEAR) ? '0 : bin_new;
   end

   pad_ram #(.WIDTH(ACC_WIDTH), .DEPTH(CELLS)) u_grid (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (addr_ff),
      .rd_data (ram_rd)
   );

   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         total_ff <= '0;
         rsp_valid_ff <= 1'b0;
         dz_ff <= 32'd655;
         dr_ff <= 32'd655;
         nz_ff <= 8'd128;
         nr_ff <= 8'd128;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               pad_pkg::CSR_DEPTH_BIN_SIZE:   dz_ff <= csr_write_data;
               pad_pkg::CSR_RADIUS_BIN_SIZE:  dr_ff <= csr_write_data;
               pad_pkg::CSR_DEPTH_BINS_USED:  nz_ff <= csr_write_data[7:0];
               pad_pkg::CSR_RADIUS_BINS_USED: nr_ff <= csr_write_data[7:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == ADDR_W'(CELLS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  type_ff <= req_type;
                  w_ff <= w_clamp;
                  mua_ff <= req_absorb_coef;
                  csum_ff <= {1'b0, req_absorb_coef} + {1'b0, req_scatter_coef};
                  ax_ff <= req_pos_x[31] ? (~req_pos_x + 32'd1) : req_pos_x;
                  ay_ff <= req_pos_y[31] ? (~req_pos_y + 32'd1) : req_pos_y;
                  zraw_ff <= req_pos_z;
                  rd_ok_ff <= (32'(req_read_radius_bin) < 32'(RADIUS_BINS_MAX))
                           && (32'(req_read_depth_bin) < 32'(DEPTH_BINS_MAX));
                  addr_ff <= ADDR_W'(32'(req_read_radius_bin) * 32'(DEPTH_BINS_MAX)
                           + 32'(req_read_depth_bin));
                  case (req_type)
                     pad_pkg::REQ_DEPOSIT:  state_ff <= S_PREP;
                     pad_pkg::REQ_READ_BIN: state_ff <= S_WAIT;
                     default:               state_ff <= S_WAIT;
                  endcase
               end
            end
            S_PREP: begin
               prod_ff <= 49'(w_ff) * 49'(mua_ff);
               axx_ff <= 64'(ax_ff) * 64'(ax_ff);
               ayy_ff <= 64'(ay_ff) * 64'(ay_ff);
               state_ff <= S_SUM;
            end
            S_SUM: begin
               rem1_ff <= {1'b0, prod_ff[48:17]};
               p_ff <= prod_ff[16:0];
               rem2_ff <= '0;
               zs_ff <= zraw_ff;
               sv_ff <= axx_ff + ayy_ff;
               srem_ff <= '0;
               root_ff <= '0;
               cnt_ff <= '0;
               state_ff <= S_ITER1;
            end
            S_ITER1: begin
               if (cnt_ff < 5'd17) begin
                  p_ff <= {p_ff[15:0], (t1 >= {1'b0, csum_ff})};
                  rem1_ff <= (t1 >= {1'b0, csum_ff}) ? 33'(t1 - {1'b0, csum_ff}) : t1[32:0];
               end
               zs_ff <= {zs_ff[30:0], (t2 >= {1'b0, dz_ff})};
               rem2_ff <= (t2 >= {1'b0, dz_ff}) ? (t2 - {1'b0, dz_ff}) : t2;
               sv_ff <= {sv_ff[61:0], 2'b00};
               srem_ff <= (st >= trial) ? (st - trial) : st;
               root_ff <= {root_ff[30:0], (st >= trial)};
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd31) begin
                  prod_ff <= {32'd0, p_ff[16:0]};
                  rs_ff <= {root_ff[30:0], (st >= trial)};
                  rem3_ff <= '0;
                  state_ff <= S_ITER2;
               end
            end
            S_ITER2: begin
               rs_ff <= {rs_ff[30:0], (t3 >= {1'b0, dr_ff})};
               rem3_ff <= (t3 >= {1'b0, dr_ff}) ? (t3 - {1'b0, dr_ff}) : t3;
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd31) begin
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               ok_ff <= !zraw_ff[31] && dz_ff != 32'd0 && dr_ff != 32'd0
                     && zs_ff < nz && rs_ff < nr;
               addr_ff <= ADDR_W'(rs_ff * 32'(DEPTH_BINS_MAX) + zs_ff);
               state_ff <= S_WAIT;
            end
            S_WAIT: begin
               // result register must be free before the modify step
               if (!rsp_valid_ff || rsp_ready) begin
                  state_ff <= S_MODIFY;
               end
            end
            S_MODIFY: begin
               rsp_wout_ff <= '0;
               rsp_dwa_ff <= '0;
               rsp_in_grid_ff <= 1'b0;
               rsp_val_ff <= '0;
               case (type_ff)
                  pad_pkg::REQ_DEPOSIT: begin
                     rsp_wout_ff <= w_ff - dwa;
                     rsp_dwa_ff <= dwa;
                     rsp_in_grid_ff <= ok_ff;
                     if (ok_ff) begin
                        total_ff <= tot_new;
                     end
                  end
                  pad_pkg::REQ_READ_BIN: begin
                     if (rd_ok_ff) begin
                        rsp_val_ff <= pad_pkg::READ_WIDTH'(ram_rd);
                     end
                  end
                  pad_pkg::REQ_READ_TOTAL: begin
                     rsp_val_ff <= pad_pkg::READ_WIDTH'(total_ff);
                  end
                  default: ;
               endcase
               state_ff <= S_FIN;
            end
            S_FIN: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_weight_out = rsp_wout_ff;
   assign rsp_absorbed   = rsp_dwa_ff;
   assign rsp_in_grid    = rsp_in_grid_ff;
   assign rsp_read_value = rsp_val_ff;
endmodule
`default_nettype wire
